@@ rtl/prm_pkg.sv @@
// Package with the types, constants and index function of the pedigree relationship block.
package prm_pkg;

  localparam int MAX_ANIMALS = 64;
  localparam int FRAC_BITS   = 16;
  localparam int ID_W        = 7;
  localparam int VAL_W       = FRAC_BITS + 2;
  localparam int STORE_DEPTH = (MAX_ANIMALS * (MAX_ANIMALS + 1)) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [VAL_W-1:0] FIXED_ONE = VAL_W'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_OFF,
    KIND_DIAG,
    KIND_ERR
  } kind_e;

  typedef struct packed {
    logic [ID_W-1:0] sire;
    logic [ID_W-1:0] dam;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]  row;
    logic [ID_W-1:0]  col;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             error;
  } out_t;

  typedef struct packed {
    logic              vld;
    kind_e             kind;
    logic [ID_W-1:0]   row;
    logic [ID_W-1:0]   col;
    logic              use_a;
    logic              use_b;
    logic [ADDR_W-1:0] waddr;
  } entry_t;

  function automatic logic [ADDR_W-1:0] tri_index(input logic [ID_W-1:0] a,
                                                  input logic [ID_W-1:0] b);
    logic [ID_W-1:0]   hi;
    logic [ID_W-1:0]   lo;
    logic [2*ID_W-1:0] prod;
    hi   = (a > b) ? a : b;
    lo   = (a > b) ? b : a;
    prod = {{ID_W{1'b0}}, hi} * {{ID_W{1'b0}}, ID_W'(hi - 1'b1)};
    return ADDR_W'(prod >> 1) + ADDR_W'(lo) - ADDR_W'(1);
  endfunction

endpackage

@@ rtl/prm_ram.sv @@
// Generic RAM with one write port and two registered read ports.
module prm_ram #(
  parameter int DEPTH = 2080,
  parameter int WIDTH = 18,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ rtl/prm_ctrl.sv @@
// Sequencer that accepts animals, checks them and issues store reads entry by entry.
module prm_ctrl import prm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  input  logic              adv_i,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_a_o,
  output logic [ADDR_W-1:0] raddr_b_o,
  output entry_t            entry_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q;
  logic [ID_W-1:0] count_q;
  logic [ID_W-1:0] n_q;
  logic [ID_W-1:0] s_q;
  logic [ID_W-1:0] d_q;
  logic [ID_W-1:0] j_q;
  entry_t          entry_q;
  entry_t          entry_d;

  logic   accept;
  logic   bad;
  logic   is_diag;
  logic   s_nz;
  logic   d_nz;
  entry_t issue;

  assign in_stall_o = (state_q != ST_IDLE) || entry_q.vld;
  assign accept     = in_valid_i && !in_stall_o;
  assign bad        = (count_q == ID_W'(MAX_ANIMALS)) || (in_data_i.sire > count_q) ||
                      (in_data_i.dam > count_q);

  assign is_diag = (j_q == n_q);
  assign s_nz    = (s_q != '0);
  assign d_nz    = (d_q != '0);
  assign re_o    = (state_q == ST_RUN) && adv_i;

  always_comb begin
    issue       = '0;
    issue.vld   = 1'b1;
    issue.row   = n_q;
    issue.col   = j_q;
    issue.waddr = tri_index(n_q, j_q);
    raddr_a_o   = '0;
    raddr_b_o   = '0;
    if (is_diag) begin
      issue.kind  = KIND_DIAG;
      issue.use_a = s_nz && d_nz;
      issue.use_b = 1'b0;
      if (s_nz && d_nz) begin
        raddr_a_o = tri_index(s_q, d_q);
      end
    end else begin
      issue.kind  = KIND_OFF;
      issue.use_a = s_nz;
      issue.use_b = d_nz;
      if (s_nz) begin
        raddr_a_o = tri_index(j_q, s_q);
      end
      if (d_nz) begin
        raddr_b_o = tri_index(j_q, d_q);
      end
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (adv_i) begin
      entry_d     = issue;
      entry_d.vld = (state_q == ST_RUN);
    end
    if ((state_q == ST_IDLE) && accept && bad) begin
      entry_d      = '0;
      entry_d.vld  = 1'b1;
      entry_d.kind = KIND_ERR;
    end
  end

  assign entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      n_q     <= '0;
      s_q     <= '0;
      d_q     <= '0;
      j_q     <= '0;
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && !bad) begin
            count_q <= count_q + 1'b1;
            n_q     <= count_q + 1'b1;
            s_q     <= in_data_i.sire;
            d_q     <= in_data_i.dam;
            j_q     <= ID_W'(1);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (adv_i) begin
            if (is_diag) begin
              state_q <= ST_IDLE;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/prm_rowgen.sv @@
// Combines the read relationships into one entry, writes it back and holds the output register.
module prm_rowgen import prm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  entry_t            entry_i,
  input  logic [VAL_W-1:0]  rdata_a_i,
  input  logic [VAL_W-1:0]  rdata_b_i,
  output logic              adv_o,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [VAL_W-1:0]  wdata_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o
);

  logic             out_vld_q;
  out_t             out_q;
  out_t             out_d;
  logic [VAL_W-1:0] half_a;
  logic [VAL_W-1:0] half_b;
  logic [VAL_W-1:0] value;

  assign adv_o = !out_vld_q || !out_stall_i;

  assign half_a = entry_i.use_a ? (rdata_a_i >> 1) : '0;
  assign half_b = entry_i.use_b ? (rdata_b_i >> 1) : '0;

  always_comb begin
    out_d = '0;
    case (entry_i.kind)
      KIND_OFF:  value = half_a + half_b;
      KIND_DIAG: value = FIXED_ONE + half_a;
      default:   value = '0;
    endcase
    if (entry_i.kind == KIND_ERR) begin
      out_d.last  = 1'b1;
      out_d.error = 1'b1;
    end else begin
      out_d.row   = entry_i.row;
      out_d.col   = entry_i.col;
      out_d.value = value;
      out_d.last  = (entry_i.kind == KIND_DIAG);
    end
  end

  assign we_o    = adv_o && entry_i.vld && (entry_i.kind != KIND_ERR);
  assign waddr_o = entry_i.waddr;
  assign wdata_o = value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o) begin
      out_vld_q <= entry_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && entry_i.vld) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/pedigree_relationship_matrix.sv @@
// Top level of the pedigree relationship matrix builder.
//
// Usage: animals of a sorted pedigree enter on the input channel as one
// transaction each, carrying a sire and a dam number (1-based, 0 unknown).
// For animal n the block emits n result transactions: the relationships to
// animals 1 to n-1 in column order and then the diagonal, marked by last.
// A parent number not below the new animal's own number, or an input after
// the store holds its full count of animals, yields one result with error set.
// Throughput: row n is issued at one entry per cycle while the receiver does
// not stall, from a store with two registered read ports. A new animal is
// accepted only after the last entry of the previous row has left the entry
// register. An accepted animal passes the state and row registers, the entry
// register and the output register; a rejected input passes the last two.
// Input stall stays high while a row is being issued.
// When the receiver stalls, the output register holds its transaction and
// the read pipeline freezes until it is taken; nothing is lost.
// Reset clears the animal count; the store needs no clearing pass, because
// only rows of animals already added are ever read.
module pedigree_relationship_matrix import prm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  entry_t            entry;
  logic              adv;
  logic              re;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [VAL_W-1:0]  rdata_a;
  logic [VAL_W-1:0]  rdata_b;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;

  prm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .re_o       (re),
    .raddr_a_o  (raddr_a),
    .raddr_b_o  (raddr_b),
    .entry_o    (entry)
  );

  prm_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (VAL_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  prm_rowgen u_rowgen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (entry),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .adv_o       (adv),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/prm_sva.sv @@
// Port-level checker of the pedigree relationship block and its bind statement.
module prm_sva import prm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |-> out_data_o.last && (out_data_o.row == '0) &&
    (out_data_o.col == '0) && (out_data_o.value == '0))
    else $error("Error transaction is not a single empty result.");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error |-> (out_data_o.col != '0) &&
    (out_data_o.col <= out_data_o.row))
    else $error("Column outside the row.");

  a_diag_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error |-> out_data_o.last == (out_data_o.col == out_data_o.row))
    else $error("Last flag does not mark the diagonal.");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !(out_valid_o && !out_data_o.last))
    else $error("New animal accepted while a row is still open.");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output transaction changed.");

endmodule

bind pedigree_relationship_matrix prm_sva u_prm_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
